// File: rtl/core/bbr_pkg.sv
// shared constants, types and codes of the row box blur
`timescale 1ns / 1ps
package bbr_pkg;

	localparam int MAX_RADIUS  = 63;
	localparam int MAX_WIDTH   = 4096;
	localparam int PIX_W       = 8;
	localparam int RGB_W       = 3 * PIX_W;
	localparam int SUM_W       = 15;
	localparam int COL_W       = 12;
	localparam int RAD_W       = 6;
	localparam int WID_W       = 13;
	localparam int TAP_W       = RAD_W + 1;
	localparam int CFG_W       = WID_W;
	localparam int WIN_DEPTH   = 128;
	localparam int WIN_AW      = $clog2(WIN_DEPTH);
	localparam int Q_DEPTH     = 4;
	localparam int Q_AW        = $clog2(Q_DEPTH);
	localparam int Q_CW        = $clog2(Q_DEPTH + 1);
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int DIV_IN_W    = SUM_W + 1;
	localparam int PROD_W      = DIV_IN_W + RECIP_W;
	localparam int QUO_W       = PROD_W - RECIP_SHIFT;

	typedef enum logic [0:0] {
		REG_RADIUS = 1'b0,
		REG_WIDTH  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		FR_RUN,
		FR_ENDROW,
		FR_FL_RD,
		FR_FL_EM
	} front_state_t;

	// effective configuration after clamping
	typedef struct packed {
		logic [RAD_W-1:0] radius;
		logic [TAP_W-1:0] taps;
		logic [WID_W-1:0] width;
	} cfg_t;

	// one output job handed from the front to the back
	typedef struct packed {
		logic [SUM_W-1:0] sum_red;
		logic [SUM_W-1:0] sum_green;
		logic [SUM_W-1:0] sum_blue;
		logic [COL_W-1:0] column;
		logic             last;
		logic             frame_end;
	} cmd_t;

endpackage

// File: rtl/core/bbr_recip.sv
// iterative divider that forms the reciprocal of the window size
`timescale 1ns / 1ps
module bbr_recip (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       kick,
	input  logic [bbr_pkg::TAP_W-1:0]  taps,
	output logic                       busy,
	output logic [bbr_pkg::RECIP_W-1:0] recip
);
	import bbr_pkg::*;

	localparam int CNT_W = $clog2(RECIP_W + 1);

	logic                start_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [RECIP_W-1:0]  quo_q;
	logic [TAP_W-1:0]    rem_q;
	logic [TAP_W:0]      trial;
	logic                fits;
	logic [TAP_W-1:0]    rem_d;
	logic [RECIP_W-1:0]  dividend;

	// ceil(2^24 / n) as floor((2^24 + n - 1) / n)
	assign dividend = {1'b1, {RECIP_SHIFT{1'b0}}} + RECIP_W'(taps) - RECIP_W'(1);
	assign trial    = {rem_q, quo_q[RECIP_W-1]};
	assign fits     = trial >= {1'b0, taps};
	assign rem_d    = fits ? TAP_W'(trial - {1'b0, taps}) : TAP_W'(trial);
	assign busy     = start_q || (cnt_q != '0);
	assign recip    = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			cnt_q   <= '0;
		end else begin
			start_q <= kick;
			if (start_q) begin
				cnt_q <= CNT_W'(RECIP_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_q) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[RECIP_W-2:0], fits};
			rem_q <= rem_d;
		end
	end

endmodule

// File: rtl/core/bbr_front.sv
// front end: pixel intake, delay line, running sums and row-end flush sequencing
`timescale 1ns / 1ps
module bbr_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bbr_pkg::cfg_t            cfg,
	input  logic                     hold,
	input  logic                     pix_valid,
	output logic                     pix_ready,
	input  logic [bbr_pkg::PIX_W-1:0] in_red,
	input  logic [bbr_pkg::PIX_W-1:0] in_green,
	input  logic [bbr_pkg::PIX_W-1:0] in_blue,
	input  logic                     frame_end_in,
	output logic                     q_push,
	output bbr_pkg::cmd_t            q_cmd,
	input  logic                     q_ready
);
	import bbr_pkg::*;

	front_state_t state_q, state_d;

	logic [RGB_W-1:0]  win_mem [WIN_DEPTH];
	logic [RGB_W-1:0]  win_rd_s1;
	logic [COL_W-1:0]  col_count_q;
	logic [SUM_W-1:0]  sum_r_q, sum_g_q, sum_b_q;
	logic [COL_W-1:0]  j_q;

	logic              valid_s1;
	logic [RGB_W-1:0]  px_s1;
	logic              sub_s1, emit_s1, row_end_s1, fend_s1;
	logic [COL_W-1:0]  col_s1, cnt_s1;

	logic              accept, s1_go, fl_go, fl_last, fl_sub, rd_en, no_flush;
	logic              c_ge_n, c_ge_r, row_end_in;
	logic [WIN_AW-1:0] rd_addr;
	logic [RGB_W-1:0]  s1_sub_px, fl_sub_px;
	logic [SUM_W-1:0]  s1_sum_r, s1_sum_g, s1_sum_b;
	logic [SUM_W-1:0]  fl_sum_r, fl_sum_g, fl_sum_b;

	assign c_ge_n     = col_count_q >= COL_W'(cfg.taps);
	assign c_ge_r     = col_count_q >= COL_W'(cfg.radius);
	assign row_end_in = frame_end_in || (({1'b0, col_count_q} + WID_W'(1)) >= cfg.width);
	assign no_flush   = cfg.radius == '0;

	// sums after the s1 pixel and after one flush step
	assign s1_sub_px = sub_s1 ? win_rd_s1 : '0;
	assign s1_sum_r  = sum_r_q - SUM_W'(s1_sub_px[23:16]) + SUM_W'(px_s1[23:16]);
	assign s1_sum_g  = sum_g_q - SUM_W'(s1_sub_px[15:8]) + SUM_W'(px_s1[15:8]);
	assign s1_sum_b  = sum_b_q - SUM_W'(s1_sub_px[7:0]) + SUM_W'(px_s1[7:0]);

	assign fl_sub    = j_q > COL_W'(cfg.radius);
	assign fl_sub_px = fl_sub ? win_rd_s1 : '0;
	assign fl_sum_r  = sum_r_q - SUM_W'(fl_sub_px[23:16]);
	assign fl_sum_g  = sum_g_q - SUM_W'(fl_sub_px[15:8]);
	assign fl_sum_b  = sum_b_q - SUM_W'(fl_sub_px[7:0]);
	assign fl_last   = j_q == cnt_s1;

	// handshake, read port and queue push
	always_comb begin
		s1_go     = valid_s1 && (!emit_s1 || q_ready);
		pix_ready = (state_q == FR_RUN) && !hold && (!valid_s1 || s1_go);
		accept    = pix_valid && pix_ready;
		fl_go     = (state_q == FR_FL_EM) && q_ready;
		rd_en     = accept || (state_q == FR_FL_RD);
		if (state_q == FR_FL_RD) begin
			rd_addr = j_q[WIN_AW-1:0] - WIN_AW'(cfg.radius) - WIN_AW'(1);
		end else begin
			rd_addr = col_count_q[WIN_AW-1:0] - WIN_AW'(cfg.taps);
		end
		q_push = (s1_go && emit_s1) || fl_go;
		if (fl_go) begin
			q_cmd.sum_red   = fl_sum_r;
			q_cmd.sum_green = fl_sum_g;
			q_cmd.sum_blue  = fl_sum_b;
			q_cmd.column    = j_q;
			q_cmd.last      = fl_last;
			q_cmd.frame_end = fl_last && fend_s1;
		end else begin
			q_cmd.sum_red   = s1_sum_r;
			q_cmd.sum_green = s1_sum_g;
			q_cmd.sum_blue  = s1_sum_b;
			q_cmd.column    = col_s1;
			q_cmd.last      = !row_end_s1 || no_flush;
			q_cmd.frame_end = fend_s1 && (!row_end_s1 || no_flush);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_RUN: begin
				if (accept && row_end_in) state_d = FR_ENDROW;
			end
			FR_ENDROW: begin
				if (s1_go) state_d = no_flush ? FR_RUN : FR_FL_RD;
			end
			FR_FL_RD: begin
				state_d = FR_FL_EM;
			end
			FR_FL_EM: begin
				if (fl_go) state_d = fl_last ? FR_RUN : FR_FL_RD;
			end
			default: begin
				state_d = FR_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FR_RUN;
			valid_s1    <= 1'b0;
			col_count_q <= '0;
			sum_r_q     <= '0;
			sum_g_q     <= '0;
			sum_b_q     <= '0;
			j_q         <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				valid_s1    <= 1'b1;
				col_count_q <= row_end_in ? '0 : col_count_q + COL_W'(1);
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				if (row_end_s1 && no_flush) begin
					sum_r_q <= '0;
					sum_g_q <= '0;
					sum_b_q <= '0;
				end else begin
					sum_r_q <= s1_sum_r;
					sum_g_q <= s1_sum_g;
					sum_b_q <= s1_sum_b;
				end
				if (row_end_s1) j_q <= emit_s1 ? col_s1 + COL_W'(1) : '0;
			end else if (fl_go) begin
				if (fl_last) begin
					sum_r_q <= '0;
					sum_g_q <= '0;
					sum_b_q <= '0;
				end else begin
					sum_r_q <= fl_sum_r;
					sum_g_q <= fl_sum_g;
					sum_b_q <= fl_sum_b;
				end
				j_q <= j_q + COL_W'(1);
			end
		end
	end

	// s1 payload stays put through the flush, accepts are blocked then
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1      <= {in_red, in_green, in_blue};
			sub_s1     <= c_ge_n;
			emit_s1    <= c_ge_r;
			col_s1     <= col_count_q - COL_W'(cfg.radius);
			cnt_s1     <= col_count_q;
			row_end_s1 <= row_end_in;
			fend_s1    <= frame_end_in;
		end
	end

	// delay line, written on intake, registered read
	always_ff @(posedge clk) begin
		if (accept) win_mem[col_count_q[WIN_AW-1:0]] <= {in_red, in_green, in_blue};
		if (rd_en) win_rd_s1 <= win_mem[rd_addr];
	end

endmodule

// File: rtl/core/bbr_queue.sv
// small job queue between front and back
`timescale 1ns / 1ps
module bbr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bbr_pkg::cmd_t cmd_in,
	output logic          ready,
	output logic          valid,
	output bbr_pkg::cmd_t cmd_out,
	input  logic          pop
);
	import bbr_pkg::*;

	cmd_t            entry_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic            do_push, do_pop;

	assign ready   = count_q != Q_CW'(Q_DEPTH);
	assign valid   = count_q != '0;
	assign cmd_out = entry_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			if (do_push && !do_pop) begin
				count_q <= count_q + Q_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - Q_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= cmd_in;
	end

endmodule

// File: rtl/core/bbr_back.sv
// back end: rounded division by the window size and output register
`timescale 1ns / 1ps
module bbr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bbr_pkg::RAD_W-1:0]   radius,
	input  logic [bbr_pkg::RECIP_W-1:0] recip,
	input  logic                        q_valid,
	input  bbr_pkg::cmd_t               q_cmd,
	output logic                        q_pop,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [bbr_pkg::PIX_W-1:0]   out_red,
	output logic [bbr_pkg::PIX_W-1:0]   out_green,
	output logic [bbr_pkg::PIX_W-1:0]   out_blue,
	output logic [bbr_pkg::COL_W-1:0]   out_column,
	output logic                        run_last,
	output logic                        frame_end_out
);
	import bbr_pkg::*;

	logic               valid_s1;
	logic [PROD_W-1:0]  prod_r_s1, prod_g_s1, prod_b_s1;
	logic [COL_W-1:0]   col_s1;
	logic               last_s1, fend_s1;
	logic               out_valid_q;
	logic [PIX_W-1:0]   out_r_q, out_g_q, out_b_q;
	logic [COL_W-1:0]   out_col_q;
	logic               out_last_q, out_fend_q;
	logic               out_free, s1_adv, s1_free;

	// floor((2s + n) / 2n) equals floor((s + r) / n) for odd n
	function automatic logic [PROD_W-1:0] scale(input logic [SUM_W-1:0] s,
		input logic [RAD_W-1:0] r, input logic [RECIP_W-1:0] m);
		logic [DIV_IN_W-1:0] x;
		x = DIV_IN_W'(s) + DIV_IN_W'(r);
		return {{RECIP_W{1'b0}}, x} * {{DIV_IN_W{1'b0}}, m};
	endfunction

	function automatic logic [PIX_W-1:0] sat(input logic [PROD_W-1:0] p);
		logic [QUO_W-1:0] q;
		q = p[PROD_W-1:RECIP_SHIFT];
		return (q[QUO_W-1:PIX_W] != '0) ? {PIX_W{1'b1}} : q[PIX_W-1:0];
	endfunction

	assign out_free = !out_valid_q || res_ready;
	assign s1_adv   = valid_s1 && out_free;
	assign s1_free  = !valid_s1 || s1_adv;
	assign q_pop    = q_valid && s1_free;

	assign res_valid     = out_valid_q;
	assign out_red       = out_r_q;
	assign out_green     = out_g_q;
	assign out_blue      = out_b_q;
	assign out_column    = out_col_q;
	assign run_last      = out_last_q;
	assign frame_end_out = out_fend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) valid_s1 <= q_valid;
			if (out_free) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_r_s1 <= scale(q_cmd.sum_red, radius, recip);
			prod_g_s1 <= scale(q_cmd.sum_green, radius, recip);
			prod_b_s1 <= scale(q_cmd.sum_blue, radius, recip);
			col_s1    <= q_cmd.column;
			last_s1   <= q_cmd.last;
			fend_s1   <= q_cmd.frame_end;
		end
		if (s1_adv) begin
			out_r_q    <= sat(prod_r_s1);
			out_g_q    <= sat(prod_g_s1);
			out_b_q    <= sat(prod_b_s1);
			out_col_q  <= col_s1;
			out_last_q <= last_s1;
			out_fend_q <= fend_s1;
		end
	end

endmodule

// File: rtl/core/box_blur_row_pass_core.sv
// top level of the horizontal box blur over RGB rows
`timescale 1ns / 1ps
// horizontal box blur over one RGB row at a time. each pixel transfer adds the pixel to three
// running channel sums over a window of 2r+1 columns, drops the pixel leaving the window from a
// 128-entry delay line, and the result for column c leaves once column c+r has arrived; columns
// outside the row count as zero with a fixed divisor of 2r+1, so row edges darken. each channel
// is the window mean rounded half up, saturated to 255. inside a row the block takes one pixel
// per clock while the job queue has room, limited by the single delay-line read per pixel; the
// last pixel of a row (width reached or frame_end_in set) stalls intake for an end-of-row state
// and a read and an emit state per flushed column, at most r columns, because the flush walks
// the delay line one read then one update at a time. after reset and every blur_radius write,
// intake waits while a bit-serial divider forms the reciprocal of 2r+1 that the back end
// multiplies by. a result passes the front s1 register, the job queue, the back s1 register and
// the output register; the 4-deep job queue lets intake run on while results wait for res_ready
// until it fills. the user must write configuration only while the block is idle (unenforced).
module box_blur_row_pass_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  bbr_pkg::reg_idx_t           cfg_index,
	input  logic [bbr_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  logic [bbr_pkg::PIX_W-1:0]   in_red,
	input  logic [bbr_pkg::PIX_W-1:0]   in_green,
	input  logic [bbr_pkg::PIX_W-1:0]   in_blue,
	input  logic                        frame_end_in,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [bbr_pkg::PIX_W-1:0]   out_red,
	output logic [bbr_pkg::PIX_W-1:0]   out_green,
	output logic [bbr_pkg::PIX_W-1:0]   out_blue,
	output logic [bbr_pkg::COL_W-1:0]   out_column,
	output logic                        run_last,
	output logic                        frame_end_out
);
	import bbr_pkg::*;

	logic [RAD_W-1:0]   radius_q;
	logic [WID_W-1:0]   width_q;
	cfg_t               cfg;
	logic               recip_kick, recip_busy;
	logic [RECIP_W-1:0] recip;
	logic               q_push, q_ready, q_valid, q_pop;
	cmd_t               push_cmd, pop_cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_W'(1);
			width_q  <= WID_W'(640);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data[WID_W-1:0];
				default:    ;
			endcase
		end
	end

	// clamp radius and width, window size n = 2r+1
	always_comb begin
		cfg.radius = (32'(radius_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_q;
		cfg.taps   = {cfg.radius, 1'b1};
		if (width_q == '0) begin
			cfg.width = WID_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			cfg.width = WID_W'(MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
	end

	// a radius write restarts the reciprocal
	assign recip_kick = cfg_we && (cfg_index == REG_RADIUS);

	bbr_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.kick   (recip_kick),
		.taps   (cfg.taps),
		.busy   (recip_busy),
		.recip  (recip)
	);

	bbr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.hold         (recip_busy),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.in_red       (in_red),
		.in_green     (in_green),
		.in_blue      (in_blue),
		.frame_end_in (frame_end_in),
		.q_push       (q_push),
		.q_cmd        (push_cmd),
		.q_ready      (q_ready)
	);

	bbr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.cmd_in  (push_cmd),
		.ready   (q_ready),
		.valid   (q_valid),
		.cmd_out (pop_cmd),
		.pop     (q_pop)
	);

	bbr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.radius        (cfg.radius),
		.recip         (recip),
		.q_valid       (q_valid),
		.q_cmd         (pop_cmd),
		.q_pop         (q_pop),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.out_red       (out_red),
		.out_green     (out_green),
		.out_blue      (out_blue),
		.out_column    (out_column),
		.run_last      (run_last),
		.frame_end_out (frame_end_out)
	);

	// no pixel transfer while the reciprocal is being formed
	a_busy_blocks_intake: assert property (@(posedge clk) disable iff (!arst_n)
		recip_busy |-> !pix_ready)
		else $error("pixel intake open while reciprocal busy");

	// the front never pushes into a full queue
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_ready)
		else $error("job queue overflow");

	// a frame end closes the row, so intake stops for the row-end sequence
	a_frame_end_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready && frame_end_in) |=> !pix_ready)
		else $error("pixel taken right after a frame end");

	// frame end only marks the last result of a pixel
	a_frame_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && frame_end_out) |-> run_last)
		else $error("frame end on a result that is not the last");

endmodule
